FILE: sv/arct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arct_pkg
// Shared constants and codes for the address reference count table.
// ----------------------------------------------------------------------------
package arct_pkg;

  localparam int unsigned BUCKETS_DEF  = 1024;
  localparam int unsigned WAYS_DEF     = 4;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_DISABLED = 3'd4
  } status_e;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_MUL1   = 6'b000100,
    S_MUL2   = 6'b001000,
    S_READ   = 6'b010000,
    S_UPDATE = 6'b100000
  } fsm_e;

endpackage
`default_nettype wire

FILE: sv/address_reference_count_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// states per item: S_MUL1, S_MUL2, S_READ, S_UPDATE; S_UPDATE holds while the output stalls
// no item overlaps the last; one bucket row read per item, written back on a hit or insert
// the bucket index comes from a two-step reciprocal multiply with one correction subtract
// reset: after rst_ni rises the memory is swept clear, one bucket a cycle, over all BUCKETS rows,
// with s_axis_tready low; table_enable resets to 1
// ----------------------------------------------------------------------------
// address_reference_count_table_top
// Set-associative table mapping address keys to signed reference counts.
// ----------------------------------------------------------------------------
module address_reference_count_table_top #(
  parameter int unsigned BUCKETS  = arct_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS     = arct_pkg::WAYS_DEF,
  parameter int unsigned KEY_BITS = arct_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_wdata_i,   // table_enable
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [arct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // key[31:0], delta[63:32]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [arct_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // ref_count[31:0], status[34:32]
);
  import arct_pkg::*;

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam logic [KEY_W-1:0] KMASK = {KEY_W{1'b1}} >> (KEY_W - KW);
  localparam logic [63:0] RECIP = (64'd1 << 32) / BUCKETS;
  localparam logic [KEY_W-1:0] BUCKETS_V = KEY_W'(BUCKETS);

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [KW-1:0]      key;
    logic               vld;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  fsm_e state_q, state_d;
  logic en_q;
  logic [BW-1:0] clr_q;
  logic [KEY_W-1:0] key_q;
  logic [COUNT_W-1:0] delta_q;
  logic [KEY_W-1:0] q_q;
  logic [KEY_W-1:0] qb_q;
  logic [BW-1:0] bucket_q;
  logic out_valid_q;
  logic [COUNT_W-1:0] out_cnt_q;
  status_e out_st_q;

  row_t mem [BUCKETS];
  row_t rd_row_q;

  logic [63:0] prod1, prod2;
  logic [KEY_W-1:0] r0, r1;
  logic [BW-1:0] bucket_d;
  logic mem_we;
  logic [BW-1:0] mem_waddr;
  row_t wr_row, upd_row;

  logic [WAYS-1:0] hit_vec, free_vec, free_oh;
  logic hit, has_free;
  logic [COUNT_W-1:0] sel_cnt, new_cnt;
  logic upd_go;
  logic [COUNT_W-1:0] res_cnt;
  status_e res_st;
  logic res_we;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_st_q, out_cnt_q};

  assign prod1 = 64'(key_q) * 64'(RECIP[31:0]);
  assign prod2 = 64'(q_q) * 64'(BUCKETS_V);
  assign r0 = key_q - qb_q;
  assign r1 = (r0 >= BUCKETS_V) ? (r0 - BUCKETS_V) : r0;
  assign bucket_d = r1[BW-1:0];

  assign upd_go = (state_q == S_UPDATE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_row_q[w].vld && (rd_row_q[w].key == key_q[KW-1:0]);
      free_vec[w] = !rd_row_q[w].vld;
    end
    free_oh  = free_vec & (~free_vec + WAYS'(1));
    hit      = |hit_vec;
    has_free = |free_vec;
    sel_cnt  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_vec[w]) begin
        sel_cnt = sel_cnt | rd_row_q[w].cnt;
      end
    end
    new_cnt = sel_cnt + delta_q;
    upd_row = rd_row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (hit && hit_vec[w]) begin
        upd_row[w].cnt = new_cnt;
      end else if (!hit && free_oh[w]) begin
        upd_row[w].cnt = delta_q;
        upd_row[w].key = key_q[KW-1:0];
        upd_row[w].vld = 1'b1;
      end
    end
  end

  always_comb begin
    res_cnt = '0;
    res_we  = 1'b0;
    priority if (!en_q) begin
      res_st = ST_DISABLED;
    end else if (hit) begin
      res_st  = ST_HIT;
      res_cnt = new_cnt;
      res_we  = 1'b1;
    end else if (delta_q == '0) begin
      res_st = ST_MISS;
    end else if (!has_free) begin
      res_st = ST_FULL;
    end else begin
      res_st  = ST_INSERTED;
      res_cnt = delta_q;
      res_we  = 1'b1;
    end
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      wr_row    = '0;
    end else begin
      mem_we    = upd_go && res_we;
      mem_waddr = bucket_q;
      wr_row    = upd_row;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_READ;
      S_READ: state_d = S_UPDATE;
      S_UPDATE: begin
        if (upd_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      en_q        <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + BW'(1);
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q   <= s_axis_tdata[KEY_W-1:0] & KMASK;
      delta_q <= s_axis_tdata[KEY_W +: COUNT_W];
    end
    if (state_q == S_MUL1) begin
      q_q <= prod1[63:32];
    end
    if (state_q == S_MUL2) begin
      qb_q <= prod2[KEY_W-1:0];
    end
    if (state_q == S_READ) begin
      bucket_q <= bucket_d;
    end
    if (upd_go) begin
      out_cnt_q <= res_cnt;
      out_st_q  <= res_st;
    end
  end

  // bucket memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_row_q <= mem[bucket_d];
    end
  end

endmodule
`default_nettype wire
